### src/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared constants and types for the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   // default widths
   localparam int CHANNEL_BITS_DEF = 8;
   localparam int HUE_BITS_DEF     = 16;

   // register stages from accepted beat to result strobe
   localparam int PIPE_LATENCY = 5;

   // hue sector, named by the colour span it covers
   typedef enum logic [2:0] {
      SECTOR_RED_TO_YELLOW   = 3'd0,
      SECTOR_YELLOW_TO_GREEN = 3'd1,
      SECTOR_GREEN_TO_CYAN   = 3'd2,
      SECTOR_CYAN_TO_BLUE    = 3'd3,
      SECTOR_BLUE_TO_MAGENTA = 3'd4,
      SECTOR_MAGENTA_TO_RED  = 3'd5
   } sector_type;

endpackage

`default_nettype wire

### src/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// hsvrgb_sector
// stage 1: hue times six, split into sector and fraction
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_sector
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int HUE_BITS     = HUE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [HUE_BITS-1:0]     in_hue,
   input  wire logic [CHANNEL_BITS-1:0] in_sat,
   input  wire logic [CHANNEL_BITS-1:0] in_val,
   output sector_type                   sector_ff,
   output logic                         valid_ff,
   output logic [HUE_BITS-1:0]          frac_ff,
   output logic [CHANNEL_BITS-1:0]      sat_ff,
   output logic [CHANNEL_BITS-1:0]      val_ff
);

   logic [HUE_BITS+2:0] scaled_in;

   // hue * 6 as hue * 4 + hue * 2
   assign scaled_in = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_type'(scaled_in[HUE_BITS+2:HUE_BITS]);
      frac_ff   <= scaled_in[HUE_BITS-1:0];
      sat_ff    <= in_sat;
      val_ff    <= in_val;
   end

endmodule

`default_nettype wire

### src/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// hsvrgb_scale
// stages 2 to 4: products for p, q and t ahead of the divide by full scale
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_scale
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int HUE_BITS     = HUE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire sector_type                in_sector,
   input  wire logic [HUE_BITS-1:0]       in_frac,
   input  wire logic [CHANNEL_BITS-1:0]   in_sat,
   input  wire logic [CHANNEL_BITS-1:0]   in_val,
   output logic                           valid_ff,
   output sector_type                     sector_ff,
   output logic [CHANNEL_BITS-1:0]        val_ff,
   output logic [2*CHANNEL_BITS-1:0]      xp_ff,
   output logic [2*CHANNEL_BITS-1:0]      xq_ff,
   output logic [2*CHANNEL_BITS-1:0]      xt_ff
);

   localparam int C  = CHANNEL_BITS;
   localparam int H  = HUE_BITS;
   localparam int KW = C + H;
   localparam logic [C-1:0]  CH_MAX   = {C{1'b1}};
   localparam logic [KW-1:0] FULL_MAX = {CH_MAX, {H{1'b0}}};

   // stage 2: f * s and v * (1 - s)
   logic                valid2_ff;
   sector_type          sector2_ff;
   logic [C-1:0]        sat2_ff;
   logic [C-1:0]        val2_ff;
   logic [KW-1:0]       fs2_ff;
   logic [2*C-1:0]      xp2_ff;
   logic [KW-1:0]       fs2_in;
   logic [2*C-1:0]      xp2_in;

   // stage 3: full scale minus f*s and minus (1-f)*s
   logic                valid3_ff;
   sector_type          sector3_ff;
   logic [C-1:0]        val3_ff;
   logic [2*C-1:0]      xp3_ff;
   logic [KW-1:0]       kq3_ff;
   logic [KW-1:0]       kt3_ff;
   logic [KW-1:0]       kq3_in;
   logic [KW-1:0]       kt3_in;

   // stage 4 products, full width
   logic [2*C+H-1:0]    pq4_in;
   logic [2*C+H-1:0]    pt4_in;

   assign fs2_in = KW'(in_frac) * KW'(in_sat);
   assign xp2_in = (2*C)'(in_val) * (2*C)'(CH_MAX - in_sat);

   assign kq3_in = FULL_MAX - fs2_ff;
   assign kt3_in = {CH_MAX - sat2_ff, {H{1'b0}}} + fs2_ff;

   assign pq4_in = (2*C+H)'(val3_ff) * (2*C+H)'(kq3_ff);
   assign pt4_in = (2*C+H)'(val3_ff) * (2*C+H)'(kt3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
         valid_ff  <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sector2_ff <= in_sector;
      sat2_ff    <= in_sat;
      val2_ff    <= in_val;
      fs2_ff     <= fs2_in;
      xp2_ff     <= xp2_in;

      sector3_ff <= sector2_ff;
      val3_ff    <= val2_ff;
      xp3_ff     <= xp2_ff;
      kq3_ff     <= kq3_in;
      kt3_ff     <= kt3_in;

      // dropping the low hue bits keeps the floor exact
      sector_ff  <= sector3_ff;
      val_ff     <= val3_ff;
      xp_ff      <= xp3_ff;
      xq_ff      <= pq4_in[2*C+H-1:H];
      xt_ff      <= pt4_in[2*C+H-1:H];
   end

endmodule

`default_nettype wire

### src/hsvrgb_route.sv
// ----------------------------------------------------------------------------
// hsvrgb_route
// stage 5: divide by full scale and route v, p, q, t by sector
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_route
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire sector_type                in_sector,
   input  wire logic [CHANNEL_BITS-1:0]   in_val,
   input  wire logic [2*CHANNEL_BITS-1:0] in_xp,
   input  wire logic [2*CHANNEL_BITS-1:0] in_xq,
   input  wire logic [2*CHANNEL_BITS-1:0] in_xt,
   output logic                           valid_ff,
   output logic [CHANNEL_BITS-1:0]        red_ff,
   output logic [CHANNEL_BITS-1:0]        green_ff,
   output logic [CHANNEL_BITS-1:0]        blue_ff
);

   localparam int C = CHANNEL_BITS;

   // floor(x / (2^C - 1)) for x up to (2^C - 1)^2
   function automatic logic [C-1:0] div_max(input logic [2*C-1:0] x);
      logic [2*C:0] y;
      y = {1'b0, x} + {{(C+1){1'b0}}, x[2*C-1:C]} + {{(2*C){1'b0}}, 1'b1};
      return y[2*C-1:C];
   endfunction

   logic [C-1:0] p_in;
   logic [C-1:0] q_in;
   logic [C-1:0] t_in;
   logic [C-1:0] red_in;
   logic [C-1:0] green_in;
   logic [C-1:0] blue_in;

   assign p_in = div_max(in_xp);
   assign q_in = div_max(in_xq);
   assign t_in = div_max(in_xt);

   always_comb begin
      case (in_sector)
         SECTOR_RED_TO_YELLOW: begin
            red_in = in_val; green_in = t_in;   blue_in = p_in;
         end
         SECTOR_YELLOW_TO_GREEN: begin
            red_in = q_in;   green_in = in_val; blue_in = p_in;
         end
         SECTOR_GREEN_TO_CYAN: begin
            red_in = p_in;   green_in = in_val; blue_in = t_in;
         end
         SECTOR_CYAN_TO_BLUE: begin
            red_in = p_in;   green_in = q_in;   blue_in = in_val;
         end
         SECTOR_BLUE_TO_MAGENTA: begin
            red_in = t_in;   green_in = p_in;   blue_in = in_val;
         end
         default: begin
            red_in = in_val; green_in = p_in;   blue_in = q_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   // p, q and t never exceed the brightness
   a_below_value: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (p_in <= in_val) && (q_in <= in_val) && (t_in <= in_val))
      else $error("p, q or t above brightness");

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// hue, saturation and brightness in, red, green and blue out, fully pipelined
// ----------------------------------------------------------------------------
//  channel  ports                                      handshake
//  request  req_hue, req_saturation, req_brightness    start high, busy low
//  result   rsp_red, rsp_green, rsp_blue               rsp_valid strobe
//
//  one beat can be accepted every cycle; busy is always low
//  each result leaves on the rsp_valid strobe, after its beat has passed
//  the five register stages: sector split, f*s and v*(1-s) multipliers,
//  subtract, v*k multipliers, divide and route
//  the receiver cannot hold results off, so the pipeline never stalls
//  synchronous reset clears only the stage valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit
   import hsvrgb_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
   parameter int HUE_BITS     = HUE_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [HUE_BITS-1:0]     req_hue,
   input  wire logic [CHANNEL_BITS-1:0] req_saturation,
   input  wire logic [CHANNEL_BITS-1:0] req_brightness,
   // result channel
   output logic                         rsp_valid,
   output logic [CHANNEL_BITS-1:0]      rsp_red,
   output logic [CHANNEL_BITS-1:0]      rsp_green,
   output logic [CHANNEL_BITS-1:0]      rsp_blue
);

   localparam int C = CHANNEL_BITS;
   localparam int H = HUE_BITS;

   logic req_accept;

   // stage 1 outputs
   logic          s1_valid;
   sector_type    s1_sector;
   logic [H-1:0]  s1_frac;
   logic [C-1:0]  s1_sat;
   logic [C-1:0]  s1_val;

   // stage 4 outputs
   logic          s4_valid;
   sector_type    s4_sector;
   logic [C-1:0]  s4_val;
   logic [2*C-1:0] s4_xp;
   logic [2*C-1:0] s4_xq;
   logic [2*C-1:0] s4_xt;

   // no back pressure anywhere in the pipe
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // hue * 6, sector and fraction
   hsvrgb_sector #(
      .CHANNEL_BITS (C),
      .HUE_BITS     (H)
   ) u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness),
      .sector_ff (s1_sector),
      .valid_ff  (s1_valid),
      .frac_ff   (s1_frac),
      .sat_ff    (s1_sat),
      .val_ff    (s1_val)
   );

   // multiplier stages for p, q and t
   hsvrgb_scale #(
      .CHANNEL_BITS (C),
      .HUE_BITS     (H)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_sector (s1_sector),
      .in_frac   (s1_frac),
      .in_sat    (s1_sat),
      .in_val    (s1_val),
      .valid_ff  (s4_valid),
      .sector_ff (s4_sector),
      .val_ff    (s4_val),
      .xp_ff     (s4_xp),
      .xq_ff     (s4_xq),
      .xt_ff     (s4_xt)
   );

   // divide by full scale and route to the output registers
   hsvrgb_route #(
      .CHANNEL_BITS (C)
   ) u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid),
      .in_sector (s4_sector),
      .in_val    (s4_val),
      .in_xp     (s4_xp),
      .in_xq     (s4_xq),
      .in_xt     (s4_xt),
      .valid_ff  (rsp_valid),
      .red_ff    (rsp_red),
      .green_ff  (rsp_green),
      .blue_ff   (rsp_blue)
   );

   // every accepted beat gives a result once it has passed every stage
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted beat produced no result");

   // no result without a matching beat accepted at the pipe input
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, PIPE_LATENCY))
      else $error("result without an accepted beat");

   // zero saturation gives grey
   a_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_saturation == '0, PIPE_LATENCY)
      |-> (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("zero saturation did not give grey");

endmodule

`default_nettype wire

### sim/tb_hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// self-checking bench for the hsv to rgb converter: a table of directed
// colours followed by random bursts of beats with random gaps, every result
// compared field by field against a hand-written colour or an in-bench conversion
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hsv_to_rgb_converter_unit;
   import hsvrgb_pkg::*;

   localparam int CH_W  = CHANNEL_BITS_DEF;
   localparam int HUE_W = HUE_BITS_DEF;

   // random beats after the directed table
   localparam int RANDOM_BEATS = 1630;
   // cycles allowed for the pipeline to empty at the end
   localparam int DRAIN_LIMIT  = 1000;
   // ring of expected colours, far deeper than the pipeline
   localparam int PEND_DEPTH   = 64;
   // room for the directed rows
   localparam int TABLE_DEPTH  = 32;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_colour_t;

   // one row of stimulus; typed rows carry a hand-written colour
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
      logic             typed;
      rgb_colour_t      colour;
   } hsv_beat_t;

   // --------------------------------------------------------------------------
   // block ports
   // --------------------------------------------------------------------------
   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic             busy;
   logic [HUE_W-1:0] req_hue        = '0;
   logic [CH_W-1:0]  req_saturation = '0;
   logic [CH_W-1:0]  req_brightness = '0;
   logic             rsp_valid;
   logic [CH_W-1:0]  rsp_red;
   logic [CH_W-1:0]  rsp_green;
   logic [CH_W-1:0]  rsp_blue;

   // side channel travelling with each beat: a hand-written expectation
   logic             beat_typed     = 1'b0;
   rgb_colour_t      beat_colour    = '0;

   // --------------------------------------------------------------------------
   // bookkeeping
   // --------------------------------------------------------------------------
   rgb_colour_t      pending_rgb[PEND_DEPTH];
   int               pend_wr        = 0;
   int               pend_rd        = 0;
   hsv_beat_t        colour_table[TABLE_DEPTH];
   int               table_rows     = 0;
   int               error_count    = 0;
   int               beats_accepted = 0;
   int               results_seen   = 0;
   int               grey_beats     = 0;
   int               sector_hits[6];

   hsv_to_rgb_converter_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #1 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // colour conversion, exact rational values truncated toward zero
   // --------------------------------------------------------------------------

   // integer part of hue * 6 picks the sector
   function automatic sector_type hue_sector(input logic [HUE_W-1:0] hue);
      logic [63:0] scaled;
      scaled = 64'(hue) * 64'd6;
      return sector_type'(3'(scaled >> HUE_W));
   endfunction

   function automatic rgb_colour_t convert_hsv(input logic [HUE_W-1:0] hue,
                                               input logic [CH_W-1:0]  sat,
                                               input logic [CH_W-1:0]  val);
      logic [63:0] ch_max;
      logic [63:0] hue_one;
      logic [63:0] full;
      logic [63:0] frac;
      logic [63:0] v;
      logic [63:0] s;
      logic [63:0] p_term;
      logic [63:0] q_term;
      logic [63:0] t_term;
      rgb_colour_t c;
      ch_max  = (64'd1 << CH_W) - 64'd1;
      hue_one = 64'd1 << HUE_W;
      full    = ch_max * hue_one;
      frac    = (64'(hue) * 64'd6) & (hue_one - 64'd1);
      v       = 64'(val);
      s       = 64'(sat);
      // p = v(1-s), q = v(1-fs), t = v(1-(1-f)s)
      p_term  = (v * (ch_max - s)) / ch_max;
      q_term  = (v * (full - frac * s)) / full;
      t_term  = (v * (full - (hue_one - frac) * s)) / full;
      case (hue_sector(hue))
         SECTOR_RED_TO_YELLOW: begin
            c = '{v[CH_W-1:0], t_term[CH_W-1:0], p_term[CH_W-1:0]};
         end
         SECTOR_YELLOW_TO_GREEN: begin
            c = '{q_term[CH_W-1:0], v[CH_W-1:0], p_term[CH_W-1:0]};
         end
         SECTOR_GREEN_TO_CYAN: begin
            c = '{p_term[CH_W-1:0], v[CH_W-1:0], t_term[CH_W-1:0]};
         end
         SECTOR_CYAN_TO_BLUE: begin
            c = '{p_term[CH_W-1:0], q_term[CH_W-1:0], v[CH_W-1:0]};
         end
         SECTOR_BLUE_TO_MAGENTA: begin
            c = '{t_term[CH_W-1:0], p_term[CH_W-1:0], v[CH_W-1:0]};
         end
         default: begin
            c = '{v[CH_W-1:0], p_term[CH_W-1:0], q_term[CH_W-1:0]};
         end
      endcase
      return c;
   endfunction

   // --------------------------------------------------------------------------
   // mismatch reporting: one line per problem, all counted
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // --------------------------------------------------------------------------
   // request monitor: every accepted beat queues its expected colour
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (beat_typed) begin
            pending_rgb[pend_wr % PEND_DEPTH] = beat_colour;
         end else begin
            pending_rgb[pend_wr % PEND_DEPTH] =
               convert_hsv(req_hue, req_saturation, req_brightness);
         end
         pend_wr++;
         beats_accepted++;
         sector_hits[hue_sector(req_hue)]++;
         if (req_saturation == '0) begin
            grey_beats++;
         end
      end
   end

   // --------------------------------------------------------------------------
   // result checker: each strobe is matched with the oldest expectation
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rgb_colour_t want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pend_wr == pend_rd) begin
            report_mismatch($sformatf("result with nothing expected r=%0d g=%0d b=%0d",
                                      rsp_red, rsp_green, rsp_blue));
         end else begin
            want = pending_rgb[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_red !== want.red) begin
               report_mismatch($sformatf("red got %0d want %0d", rsp_red, want.red));
            end
            if (rsp_green !== want.green) begin
               report_mismatch($sformatf("green got %0d want %0d", rsp_green, want.green));
            end
            if (rsp_blue !== want.blue) begin
               report_mismatch($sformatf("blue got %0d want %0d", rsp_blue, want.blue));
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------

   // present one beat and hold it until the block takes it
   task automatic drive_beat(input hsv_beat_t beat);
      req_hue        <= beat.hue;
      req_saturation <= beat.saturation;
      req_brightness <= beat.brightness;
      beat_typed     <= beat.typed;
      beat_colour    <= beat.colour;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // sender gap; start is only lowered when there is a gap to leave
   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start      <= 1'b0;
         beat_typed <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic add_row(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                          input logic [CH_W-1:0] val, input logic typed,
                          input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                          input logic [CH_W-1:0] b);
      colour_table[table_rows] = '{hue, sat, val, typed, '{r, g, b}};
      table_rows++;
   endtask

   // random hue, leaning on the sector edges and the ends of the range
   function automatic logic [HUE_W-1:0] random_hue();
      logic [HUE_W-1:0] edges[6];
      int               pick;
      edges = '{16'd0, 16'd10923, 16'd21846, 16'd32768, 16'd43691, 16'd54614};
      pick  = $urandom_range(0, 9);
      if (pick < 2) begin
         // wraps below zero onto the top of the range on purpose
         return edges[$urandom_range(0, 5)] + HUE_W'($urandom_range(0, 4)) - HUE_W'(2);
      end else if (pick == 2) begin
         return ($urandom_range(0, 1) != 0) ? '1 : '0;
      end else begin
         return HUE_W'($urandom);
      end
   endfunction

   // random channel, with the two ends more likely than a flat spread gives
   function automatic logic [CH_W-1:0] random_channel();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end else begin
         return CH_W'($urandom);
      end
   endfunction

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      hsv_beat_t beat;
      int        sent;
      int        burst;
      int        drain;

      // directed colours; typed ones read straight off the conversion
      add_row(16'd0,     8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0);   // pure red
      add_row(16'd32768, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255); // pure cyan
      add_row(16'd0,     8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255); // white
      add_row(16'd12345, 8'd0,   8'd200, 1'b1, 8'd200, 8'd200, 8'd200); // grey
      add_row(16'd65535, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0);   // black, top hue
      add_row(16'd40000, 8'd128, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0);   // black
      // either side of every sector edge
      add_row(16'd10922, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd10923, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd21845, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd21846, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd32767, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd43690, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd43691, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd54613, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd54614, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd65535, 8'd255, 8'd255, 1'b0, '0, '0, '0);
      // a tiny hue, then small and mid-range channels
      add_row(16'd1,     8'd255, 8'd255, 1'b0, '0, '0, '0);
      add_row(16'd65535, 8'd1,   8'd1,   1'b0, '0, '0, '0);
      add_row(16'd16384, 8'd170, 8'd85,  1'b0, '0, '0, '0);
      add_row(16'd5461,  8'd85,  8'd170, 1'b0, '0, '0, '0);
      add_row(16'd50000, 8'd254, 8'd127, 1'b0, '0, '0, '0);

      // synchronous reset held at the start, then released
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table, mostly back to back with the odd short gap
      for (int i = 0; i < table_rows; i++) begin
         drive_beat(colour_table[i]);
         idle_for(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end
      idle_for(PIPE_LATENCY + 2);

      // random bursts; about one burst in four is followed by no gap at all
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && sent < RANDOM_BEATS) begin
            beat.hue        = random_hue();
            beat.saturation = random_channel();
            beat.brightness = random_channel();
            beat.typed      = 1'b0;
            beat.colour     = '0;
            drive_beat(beat);
            burst--;
            sent++;
         end
         idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      end
      start      <= 1'b0;
      beat_typed <= 1'b0;

      // let the pipeline empty, then wait on for any stray strobe
      drain = 0;
      while (pend_wr != pend_rd && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (pend_wr != pend_rd) begin
         report_mismatch($sformatf("%0d expected colours never arrived", pend_wr - pend_rd));
      end

      $display("beats %0d, results %0d, grey %0d, mismatches %0d",
               beats_accepted, results_seen, grey_beats, error_count);
      $display("sector hits %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
               sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
